// ===== rtl/core/activity_selection_scheduler_unit_macros.svh =====
// ---------------------------------------------------------------------------
// activity selection scheduler assertion macros
// shared property forms for the scheduler checker
// ---------------------------------------------------------------------------
`ifndef ACTIVITY_SELECTION_SCHEDULER_UNIT_MACROS_SVH
`define ACTIVITY_SELECTION_SCHEDULER_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define ASU_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler same-cycle check failed");

// next-cycle implication, quiet during reset
`define ASU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler next-cycle check failed");

// next-cycle implication that also covers reset itself
`define ASU_ASSERT_RST(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scheduler reset check failed");

`endif

// ===== rtl/core/asu_pkg.sv =====
// ---------------------------------------------------------------------------
// asu_pkg
// shared constants and result type of the activity selection scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package asu_pkg;

  // default capacity and time width
  localparam int MAX_EVENTS_DEF = 64;
  localparam int TIME_BITS_DEF  = 16;

  // results per job and width of the reported index
  localparam int RESULT_LIMIT = 64;
  localparam int INDEX_W      = 6;

  typedef struct packed {
    logic [INDEX_W-1:0] event_index;
    logic               last_chosen;
    logic               overflow;
  } asu_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/asu_out_reg.sv =====
// ---------------------------------------------------------------------------
// asu_out_reg
// result output register, parts the sequencer from the receiver
// ---------------------------------------------------------------------------
`default_nettype none

module asu_out_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  asu_pkg::asu_result_t        push_data,
  output logic                        can_push,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [asu_pkg::INDEX_W-1:0] event_index,
  output logic                        last_chosen,
  output logic                        overflow
);
  import asu_pkg::*;

  asu_result_t held;
  logic        held_valid;

  // room when empty or when the held result leaves this cycle
  assign can_push = !held_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (push) begin
      held_valid <= 1'b1;
    end else if (out_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= push_data;
    end
  end

  assign out_valid   = held_valid;
  assign event_index = held.event_index;
  assign last_chosen = held.last_chosen;
  assign overflow    = held.overflow;

endmodule

`default_nettype wire

// ===== rtl/core/activity_selection_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// activity selection scheduler
// Greedy earliest-finish scheduler. Events stream in on the input channel,
// one transfer per cycle, each a start and end time; last_event closes the
// job. Events past MAX_EVENTS are dropped and flagged in overflow.
// After the closing event, in_ready drops while one comparator walks a
// selection sort of the stored end times (one compare per cycle through a
// single key memory read port), then a greedy pass reads each event in end
// order and emits the chosen load positions. Results leave through an
// output register: a receiver stall holds the sequencer only when a new
// result is ready to be pushed, and in_ready returns once the final
// result (last_chosen set) has been pushed.
// Reset empties the output register, clears the event count, overflow
// flag and last chosen end, and returns to loading; memories keep contents.
// ---------------------------------------------------------------------------
`default_nettype none

module activity_selection_scheduler_unit #(
  parameter int MAX_EVENTS = asu_pkg::MAX_EVENTS_DEF,
  parameter int TIME_BITS  = asu_pkg::TIME_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [TIME_BITS-1:0]        start_time,
  input  logic [TIME_BITS-1:0]        end_time,
  input  logic                        last_event,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [asu_pkg::INDEX_W-1:0] event_index,
  output logic                        last_chosen,
  output logic                        overflow
);
  import asu_pkg::*;

  // address width of the event memories and width of a count up to capacity
  localparam int AW  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CW  = $clog2(MAX_EVENTS + 1);
  localparam int RCW = $clog2(RESULT_LIMIT + 1);
  localparam logic [CW-1:0]  CAP   = CW'(MAX_EVENTS);
  localparam logic [RCW-1:0] R_LIM = RCW'(RESULT_LIMIT);

  typedef enum logic [11:0] {
    ST_LOAD       = 12'b0000_0000_0001,
    ST_PASS_START = 12'b0000_0000_0010,
    ST_PASS_HEAD  = 12'b0000_0000_0100,
    ST_PASS_SCAN  = 12'b0000_0000_1000,
    ST_SWAP_RD_A  = 12'b0000_0001_0000,
    ST_SWAP_RD_B  = 12'b0000_0010_0000,
    ST_SWAP_WR_A  = 12'b0000_0100_0000,
    ST_SWAP_WR_B  = 12'b0000_1000_0000,
    ST_SEL_RD     = 12'b0001_0000_0000,
    ST_SEL_IDX    = 12'b0010_0000_0000,
    ST_SEL_EVAL   = 12'b0100_0000_0000,
    ST_FLUSH      = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // job bookkeeping
  logic [CW-1:0]        count;
  logic                 dropped;
  logic [TIME_BITS-1:0] last_end;

  // sort loop registers
  logic [CW-1:0]        pos;
  logic [CW-1:0]        k;
  logic [CW-1:0]        kq_idx;
  logic [AW-1:0]        best;
  logic [TIME_BITS-1:0] best_end;
  logic [TIME_BITS-1:0] pos_key;
  logic [AW-1:0]        ord_pos;

  // selection registers
  logic [AW-1:0]        sel_idx;
  logic                 pend_valid;
  logic [AW-1:0]        pend_idx;
  logic [RCW-1:0]       chosen_cnt;

  // event memories: start and end per load position
  logic [TIME_BITS-1:0] start_mem [MAX_EVENTS];
  logic [TIME_BITS-1:0] end_mem   [MAX_EVENTS];
  // sort memories: key is the end time in sorted position, order the index
  logic [TIME_BITS-1:0] key_mem   [MAX_EVENTS];
  logic [AW-1:0]        order_mem [MAX_EVENTS];

  logic [TIME_BITS-1:0] start_q, end_q, key_q;
  logic [AW-1:0]        ord_q;

  logic                 load_fire, room, ev_we;
  logic                 key_we, ord_we;
  logic [AW-1:0]        key_waddr, ord_waddr, key_raddr, ord_raddr, ev_raddr;
  logic [TIME_BITS-1:0] key_wdata;
  logic [AW-1:0]        ord_wdata;
  logic                 chosen, can_push, push;
  logic                 sel_last;
  asu_result_t          push_data;
  logic [AW+INDEX_W-1:0] pend_wide;

  assign in_ready  = (state == ST_LOAD);
  assign load_fire = in_valid && in_ready;
  assign room      = (count < CAP);
  assign ev_we     = load_fire && room;

  // first event in end order is always taken, later ones must not overlap
  assign chosen   = (k == '0) || (start_q >= last_end);
  // this event is the final one scanned
  assign sel_last = (k + CW'(1) == count);

  // memory port steering
  always_comb begin
    key_we    = 1'b0;
    ord_we    = 1'b0;
    key_waddr = count[AW-1:0];
    ord_waddr = count[AW-1:0];
    key_wdata = end_time;
    ord_wdata = count[AW-1:0];
    case (state)
      ST_LOAD: begin
        // identity order and key copy are built while loading
        key_we = ev_we;
        ord_we = ev_we;
      end
      ST_SWAP_WR_A: begin
        key_we    = 1'b1;
        ord_we    = 1'b1;
        key_waddr = pos[AW-1:0];
        ord_waddr = pos[AW-1:0];
        key_wdata = best_end;
        ord_wdata = ord_q;
      end
      ST_SWAP_WR_B: begin
        key_we    = 1'b1;
        ord_we    = 1'b1;
        key_waddr = best;
        ord_waddr = best;
        key_wdata = pos_key;
        ord_wdata = ord_pos;
      end
      default: begin
        key_we = 1'b0;
        ord_we = 1'b0;
      end
    endcase
  end

  assign key_raddr = (state == ST_PASS_START) ? pos[AW-1:0] : k[AW-1:0];
  assign ev_raddr  = (state == ST_SEL_IDX) ? ord_q : sel_idx;

  always_comb begin
    case (state)
      ST_SWAP_RD_A: ord_raddr = pos[AW-1:0];
      ST_SWAP_RD_B: ord_raddr = best;
      default:      ord_raddr = k[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ev_we) begin
      start_mem[count[AW-1:0]] <= start_time;
      end_mem[count[AW-1:0]]   <= end_time;
    end
    start_q <= start_mem[ev_raddr];
    end_q   <= end_mem[ev_raddr];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_q <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      order_mem[ord_waddr] <= ord_wdata;
    end
    ord_q <= order_mem[ord_raddr];
  end

  // pending choice goes out when the next one is found, or marked last at the end
  assign push = ((state == ST_SEL_EVAL) && chosen && pend_valid && can_push) ||
                ((state == ST_FLUSH) && can_push);

  assign pend_wide = {{INDEX_W{1'b0}}, pend_idx};

  always_comb begin
    push_data.event_index = pend_wide[INDEX_W-1:0];
    push_data.last_chosen = (state == ST_FLUSH);
    push_data.overflow    = dropped;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      count      <= '0;
      dropped    <= 1'b0;
      last_end   <= '0;
      pos        <= '0;
      k          <= '0;
      kq_idx     <= '0;
      pend_valid <= 1'b0;
      chosen_cnt <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (load_fire) begin
            if (room) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (last_event) begin
              pos   <= '0;
              state <= ST_PASS_START;
            end
          end
        end
        ST_PASS_START: begin
          if (pos + CW'(1) >= count) begin
            // sort done, start the greedy walk
            k          <= '0;
            chosen_cnt <= '0;
            pend_valid <= 1'b0;
            state      <= ST_SEL_RD;
          end else begin
            k     <= pos + CW'(1);
            state <= ST_PASS_HEAD;
          end
        end
        ST_PASS_HEAD: begin
          best_end <= key_q;
          pos_key  <= key_q;
          best     <= pos[AW-1:0];
          kq_idx   <= k;
          k        <= k + CW'(1);
          state    <= ST_PASS_SCAN;
        end
        ST_PASS_SCAN: begin
          // strict less keeps the first minimum
          if (key_q < best_end) begin
            best_end <= key_q;
            best     <= kq_idx[AW-1:0];
          end
          if (kq_idx + CW'(1) == count) begin
            state <= ST_SWAP_RD_A;
          end else begin
            kq_idx <= k;
            k      <= k + CW'(1);
          end
        end
        ST_SWAP_RD_A: begin
          state <= ST_SWAP_RD_B;
        end
        ST_SWAP_RD_B: begin
          ord_pos <= ord_q;
          state   <= ST_SWAP_WR_A;
        end
        ST_SWAP_WR_A: begin
          state <= ST_SWAP_WR_B;
        end
        ST_SWAP_WR_B: begin
          pos   <= pos + CW'(1);
          state <= ST_PASS_START;
        end
        ST_SEL_RD: begin
          state <= ST_SEL_IDX;
        end
        ST_SEL_IDX: begin
          sel_idx <= ord_q;
          state   <= ST_SEL_EVAL;
        end
        ST_SEL_EVAL: begin
          if (chosen) begin
            if (!(pend_valid && !can_push)) begin
              pend_idx   <= sel_idx;
              pend_valid <= 1'b1;
              last_end   <= end_q;
              chosen_cnt <= chosen_cnt + RCW'(1);
              if ((chosen_cnt + RCW'(1) == R_LIM) || sel_last) begin
                state <= ST_FLUSH;
              end else begin
                k     <= k + CW'(1);
                state <= ST_SEL_RD;
              end
            end
          end else if (sel_last) begin
            state <= ST_FLUSH;
          end else begin
            k     <= k + CW'(1);
            state <= ST_SEL_RD;
          end
        end
        ST_FLUSH: begin
          if (can_push) begin
            count      <= '0;
            dropped    <= 1'b0;
            pend_valid <= 1'b0;
            state      <= ST_LOAD;
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  asu_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_data   (push_data),
    .can_push    (can_push),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_index (event_index),
    .last_chosen (last_chosen),
    .overflow    (overflow)
  );

endmodule

`default_nettype wire

// ===== rtl/core/asu_checker.sv =====
// ---------------------------------------------------------------------------
// asu_checker
// port-level checks of the activity selection scheduler
// ---------------------------------------------------------------------------
`default_nettype none

`include "activity_selection_scheduler_unit_macros.svh"

module asu_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        last_event,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [asu_pkg::INDEX_W-1:0] event_index,
  input logic                        last_chosen
);

  // a closing transfer starts the sort, so loading stops
  `ASU_ASSERT_NEXT(a_busy_after_close, in_valid && in_ready && last_event, !in_ready)

  // while a non-final result waits, the job is still running
  `ASU_ASSERT_IMP(a_busy_mid_job, out_valid && !last_chosen, !in_ready)

  // a stalled result holds
  `ASU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(event_index) && $stable(last_chosen))

  // reset leaves the block loading with nothing to deliver
  `ASU_ASSERT_RST(a_reset_idle, rst, !out_valid && in_ready)

endmodule

bind activity_selection_scheduler_unit asu_checker u_asu_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .last_event  (last_event),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .event_index (event_index),
  .last_chosen (last_chosen)
);

`default_nettype wire

// ===== tb/activity_selection_scheduler_unit_tb.sv =====
// ---------------------------------------------------------------------------
// activity selection scheduler testbench
// Streams jobs of events into the scheduler and checks every chosen index
// against an in-bench model of the earliest-finish greedy selection. A short
// directed set covers extremes, ties, inverted events and exact end/start
// chaining. Random jobs follow, mostly short, with a capacity overflow job
// and a full non-overlapping job. Sender gaps and receiver stalls change
// from phase to phase.
// ---------------------------------------------------------------------------
`default_nettype none

module activity_selection_scheduler_unit_tb;
  import asu_pkg::*;

  localparam int TB_TIME_BITS = TIME_BITS_DEF;
  localparam int TB_MAX       = MAX_EVENTS_DEF;
  // cycles with no transfer before the run is declared hung
  localparam int HANG_LIMIT   = 20000;
  // quiet cycles after the last expected result
  localparam int DRAIN_CYCLES = 64;
  // random items per idling phase
  localparam int PHASE_ITEMS  = 82;

  typedef logic [TB_TIME_BITS-1:0] time_word_t;

  // model of the scheduler plus the queue of chosen indices still owed
  class schedule_board;
    time_word_t   starts [TB_MAX];
    time_word_t   ends   [TB_MAX];
    int unsigned  order  [TB_MAX];
    int unsigned  loaded;
    bit           dropped;
    time_word_t   last_end_q;
    asu_result_t  chosen_q[$];
    int unsigned  mismatches;

    function new();
      loaded     = 0;
      dropped    = 1'b0;
      last_end_q = '0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return chosen_q.size();
    endfunction

    // one accepted event; a closing event runs sort and greedy pick
    function void note_event(time_word_t s, time_word_t e, logic l);
      int unsigned n, p, k, best, tmp, cnt;
      time_word_t  best_end;
      asu_result_t held;
      bit          have;
      if (loaded < TB_MAX) begin
        starts[loaded] = s;
        ends[loaded]   = e;
        loaded++;
      end else begin
        dropped = 1'b1;
      end
      if (!l) return;
      n = loaded;
      // selection sort by end time, first strict minimum wins
      for (p = 0; p < n; p++) order[p] = p;
      for (p = 0; p < n; p++) begin
        best     = p;
        best_end = ends[order[p]];
        for (k = p; k < n; k++) begin
          if (ends[order[k]] < best_end) begin
            best_end = ends[order[k]];
            best     = k;
          end
        end
        tmp         = order[p];
        order[p]    = order[best];
        order[best] = tmp;
      end
      // greedy walk; hold one result back so the final one gets the flag
      have = 1'b0;
      cnt  = 0;
      for (k = 0; k < n && cnt < RESULT_LIMIT; k++) begin
        if (k == 0 || starts[order[k]] >= last_end_q) begin
          last_end_q = ends[order[k]];
          if (have) chosen_q.push_back(held);
          held.event_index = order[k][INDEX_W-1:0];
          held.last_chosen = 1'b0;
          held.overflow    = dropped;
          have = 1'b1;
          cnt++;
        end
      end
      if (have) begin
        held.last_chosen = 1'b1;
        chosen_q.push_back(held);
      end
      loaded  = 0;
      dropped = 1'b0;
    endfunction

    // one accepted result against the oldest owed one
    function void check_choice(logic [INDEX_W-1:0] idx, logic lc, logic ov);
      asu_result_t want;
      if (chosen_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: index %0d last %0b overflow %0b", idx, lc, ov);
        return;
      end
      want = chosen_q.pop_front();
      if (want.event_index !== idx || want.last_chosen !== lc || want.overflow !== ov) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected index %0d last %0b overflow %0b, got %0d %0b %0b",
                   want.event_index, want.last_chosen, want.overflow, idx, lc, ov);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst         = 1'b1;
  logic                in_valid    = 1'b0;
  logic                in_ready;
  time_word_t          start_time  = '0;
  time_word_t          end_time    = '0;
  logic                last_event  = 1'b0;
  logic                out_valid;
  logic                out_ready   = 1'b0;
  logic [INDEX_W-1:0]  event_index;
  logic                last_chosen;
  logic                overflow;

  schedule_board board = new();
  int unsigned   send_idle_pct  = 0;
  int unsigned   recv_stall_pct = 0;
  int unsigned   phase_sent;
  int unsigned   hang_count = 0;

  activity_selection_scheduler_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .start_time  (start_time),
    .end_time    (end_time),
    .last_event  (last_event),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_index (event_index),
    .last_chosen (last_chosen),
    .overflow    (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls, check on every output transfer
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_choice(event_index, last_chosen, overflow);
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      hang_count <= 0;
    end else if (hang_count >= HANG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      hang_count <= hang_count + 1;
    end
  end

  // one event transfer, with optional idle cycles ahead of it
  task automatic push_event(input time_word_t s, input time_word_t e, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    start_time <= s;
    end_time   <= e;
    last_event <= l;
    do @(posedge clk); while (!in_ready);
    // predicted right at the transfer so the owed queue is never behind
    board.note_event(s, e, l);
    phase_sent++;
  endtask

  // sender holds off until every owed result has arrived
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // random job of n events; narrow times give many ties and touching events
  task automatic random_job(input int unsigned n);
    int unsigned k;
    bit          narrow;
    time_word_t  s, e;
    narrow = ($urandom_range(1) == 0);
    for (k = 0; k < n; k++) begin
      if (narrow) begin
        s = time_word_t'($urandom_range(200));
        e = time_word_t'($urandom_range(s + 40, s));
      end else begin
        s = time_word_t'($urandom_range(16'hffff));
        e = time_word_t'($urandom_range(16'hffff, s));
      end
      // occasional inverted event or extreme corner as noise
      case ($urandom_range(15))
        0: begin
          s = time_word_t'($urandom_range(16'hffff));
          e = time_word_t'($urandom_range(s));
        end
        1: begin s = 16'hffff; e = 16'h0000; end
        2: begin s = 16'h0000; e = 16'hffff; end
        default: ;
      endcase
      push_event(s, e, k == n - 1);
    end
  endtask

  // 64 back-to-back slots loaded in shuffled order: every event is chosen
  task automatic full_disjoint_job();
    int unsigned slot [TB_MAX];
    int unsigned k, j, tmp;
    for (k = 0; k < TB_MAX; k++) slot[k] = k;
    for (k = TB_MAX - 1; k > 0; k--) begin
      j       = $urandom_range(k);
      tmp     = slot[k];
      slot[k] = slot[j];
      slot[j] = tmp;
    end
    for (k = 0; k < TB_MAX; k++)
      push_event(time_word_t'(slot[k] * 1000), time_word_t'(slot[k] * 1000 + 999),
                 k == TB_MAX - 1);
  endtask

  task automatic random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                              input int unsigned special);
    int unsigned pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    phase_sent     = 0;
    // capacity overflow: two events dropped, the closing one among them
    if (special == 1) random_job(TB_MAX + 2);
    if (special == 2) full_disjoint_job();
    while (phase_sent < PHASE_ITEMS) begin
      pick = $urandom_range(9);
      if (pick < 6)      random_job($urandom_range(4, 1));
      else if (pick < 9) random_job($urandom_range(10, 5));
      else               random_job($urandom_range(20, 11));
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-event jobs at both extremes
    push_event(16'h0000, 16'h0000, 1'b1);
    push_event(16'hffff, 16'hffff, 1'b1);
    // inverted events accepted as given
    push_event(16'hffff, 16'h0000, 1'b0);
    push_event(16'h0000, 16'hffff, 1'b0);
    push_event(16'h8000, 16'h7fff, 1'b1);
    // equal end times keep the sort's tie order
    push_event(16'h0010, 16'h0100, 1'b0);
    push_event(16'h0020, 16'h0100, 1'b0);
    push_event(16'h0100, 16'h0200, 1'b0);
    push_event(16'h0100, 16'h0200, 1'b0);
    push_event(16'h0005, 16'h0050, 1'b1);
    // start equal to the last chosen end is still chosen
    push_event(16'h0000, 16'h0100, 1'b0);
    push_event(16'h0100, 16'h0200, 1'b0);
    push_event(16'h0200, 16'h0300, 1'b0);
    push_event(16'h00ff, 16'h0300, 1'b0);
    push_event(16'h0300, 16'hffff, 1'b1);
    // alternating bit patterns
    push_event(16'haaaa, 16'h5555, 1'b0);
    push_event(16'h5555, 16'haaaa, 1'b1);
    wait_idle();

    random_phase(0, 0, 0);
    random_phase(45, 0, 1);
    random_phase(0, 45, 2);
    random_phase(12, 12, 0);

    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
